>>> rtl/ctt_pkg.sv
// shared types, codes and helper functions of the config text tokenizer
// no dependencies
`default_nettype none

package ctt_pkg;

    localparam int TEXT_ADDR_WIDTH_DEF = 16;

    // token codes
    localparam logic [3:0] TK_EOF    = 4'd0;
    localparam logic [3:0] TK_END    = 4'd1;
    localparam logic [3:0] TK_SLASH  = 4'd2;
    localparam logic [3:0] TK_STAR   = 4'd3;
    localparam logic [3:0] TK_DOT    = 4'd4;
    localparam logic [3:0] TK_STRING = 4'd5;
    localparam logic [3:0] TK_INT    = 4'd6;
    localparam logic [3:0] TK_OPEN   = 4'd7;
    localparam logic [3:0] TK_CLOSE  = 4'd8;
    localparam logic [3:0] TK_ERROR  = 4'd9;

    // result kinds
    localparam logic RK_TOKEN = 1'b0;
    localparam logic RK_WRITE = 1'b1;

    // characters
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [30:0] INT_MAX  = 31'h7fff_ffff;
    localparam logic [19:0] LINE_MAX = 20'hf_ffff;
    localparam logic [15:0] COL_MAX  = 16'hffff;

    localparam int MAX_RESULTS = 4;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b000_0001,
        PH_IDENT  = 7'b000_0010,
        PH_NUMBER = 7'b000_0100,
        PH_OPEN   = 7'b000_1000,
        PH_BLOCK  = 7'b001_0000,
        PH_ERROR  = 7'b010_0000,
        PH_DONE   = 7'b100_0000
    } phase_t;

    typedef struct packed {
        logic        result_kind;
        logic [3:0]  token_kind;
        logic [30:0] token_value;
        logic [15:0] text_addr;
        logic [7:0]  text_byte;
        logic [19:0] error_line;
        logic [15:0] error_column;
    } res_t;

    // all results of one item
    typedef struct packed {
        logic [2:0]                  count;
        res_t [MAX_RESULTS-1:0]      res;
    } batch_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7a], [8'h41:8'h5a]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic res_t tok_res(input logic [3:0] kind, input logic [30:0] value);
        res_t r;
        r              = '0;
        r.result_kind  = RK_TOKEN;
        r.token_kind   = kind;
        r.token_value  = value;
        return r;
    endfunction

    function automatic res_t wr_res(input logic [15:0] addr, input logic [7:0] b);
        res_t r;
        r              = '0;
        r.result_kind  = RK_WRITE;
        r.text_addr    = addr;
        r.text_byte    = b;
        return r;
    endfunction

    function automatic res_t err_res(input logic [19:0] line, input logic [15:0] col);
        res_t r;
        r              = '0;
        r.result_kind  = RK_TOKEN;
        r.token_kind   = TK_ERROR;
        r.error_line   = line;
        r.error_column = col;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ctt_if.sv
// channel interfaces of the config text tokenizer: character items in, results out
// no dependencies
`default_nettype none

interface ctt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_input;

    modport source (output valid, output char_byte, output end_of_input, input ready);
    modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface ctt_token_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [3:0]  token_kind;
    logic [30:0] token_value;
    logic [15:0] text_addr;
    logic [7:0]  text_byte;
    logic [19:0] error_line;
    logic [15:0] error_column;
    logic        last_result;

    modport source (output valid, output result_kind, output token_kind, output token_value,
                    output text_addr, output text_byte, output error_line,
                    output error_column, output last_result, input ready);
    modport sink   (input valid, input result_kind, input token_kind, input token_value,
                    input text_addr, input text_byte, input error_line,
                    input error_column, input last_result, output ready);
endinterface

`default_nettype wire

>>> rtl/config_text_tokenizer.sv
// top level of the config text tokenizer: input register, lexer, result buffer
// depends on ctt_pkg, ctt_if, ctt_lexer and ctt_result_buf
`default_nettype none

// Tokenizer for a small configuration text. Each item on char_in is one
// character byte or an end-of-input mark; the tokens and text store writes
// it causes leave on tok_out in order, the final one of each item flagged by
// last_result. An accepted item sits in an input register; the lexer works it
// in one pass of logic into up to four results, which load a result buffer
// that drains one result per cycle while tok_out is ready. Items that yield
// zero or one result thus flow back to back; an item that yields more holds
// the single output port until its last result leaves, and the next item
// waits in the input register meanwhile. After an error token the block
// drops every item without result until reset. Reset takes effect at once:
// there is no clearing pass, and the text store itself lives outside the
// block, fed by the write results.
module config_text_tokenizer #(
    parameter int TEXT_ADDR_WIDTH = ctt_pkg::TEXT_ADDR_WIDTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ctt_char_if.sink      char_in,
    ctt_token_if.source   tok_out
);

    // input register
    logic            in_valid_reg;
    logic [7:0]      in_char_reg;
    logic            in_eoi_reg;

    logic            buf_free;
    logic            advance;
    ctt_pkg::batch_t batch;

    // the held item moves on once the result buffer can take its results
    assign advance       = in_valid_reg && buf_free;
    assign char_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (char_in.ready)
        begin
            in_valid_reg <= char_in.valid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (char_in.valid && char_in.ready)
        begin
            in_char_reg <= char_in.char_byte;
            in_eoi_reg  <= char_in.end_of_input;
        end
    end

    // lexer state and per-item logic
    ctt_lexer #(
        .TEXT_ADDR_WIDTH (TEXT_ADDR_WIDTH)
    ) u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .char_byte    (in_char_reg),
        .end_of_input (in_eoi_reg),
        .batch        (batch)
    );

    // result register, one result out per cycle while tok_out is ready
    ctt_result_buf u_result_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance),
        .batch   (batch),
        .free    (buf_free),
        .res_out (tok_out)
    );

endmodule

`default_nettype wire

>>> rtl/ctt_lexer.sv
// lexer state and the single-pass next-state / result logic for one item
// depends on ctt_pkg
`default_nettype none

module ctt_lexer #(
    parameter int TEXT_ADDR_WIDTH = ctt_pkg::TEXT_ADDR_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic [7:0]    char_byte,
    input  wire logic          end_of_input,
    output ctt_pkg::batch_t    batch
);

    localparam int LenW = TEXT_ADDR_WIDTH + 1;

    ctt_pkg::phase_t              phase_reg, phase_next;
    logic [1:0]                   brace_reg, brace_next;
    logic [30:0]                  acc_reg, acc_next;
    logic [LenW-1:0]              len_reg, len_next;
    logic [TEXT_ADDR_WIDTH-1:0]   start_reg, start_next;
    logic [19:0]                  line_reg, line_next;
    logic [15:0]                  col_reg, col_next;
    logic                         nl_reg, nl_next;
    logic [19:0]                  bline_reg, bline_next;
    logic [15:0]                  bcol_reg, bcol_next;

    logic [34:0]                  acc_sum;

    assign acc_sum = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                   + 35'(char_byte - ctt_pkg::CH_ZERO);

    always_comb
    begin
        logic [2:0]  n;
        logic        ok;
        logic        disp;
        ctt_pkg::res_t [ctt_pkg::MAX_RESULTS-1:0] res;

        n          = 3'd0;
        ok         = 1'b1;
        disp       = 1'b0;
        res        = '0;
        phase_next = phase_reg;
        brace_next = brace_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        start_next = start_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        nl_next    = nl_reg;
        bline_next = bline_reg;
        bcol_next  = bcol_reg;

        if (phase_reg == ctt_pkg::PH_ERROR)
        begin
            n = 3'd0;
        end
        else if (end_of_input)
        begin
            case (phase_reg)
                ctt_pkg::PH_IDENT:
                begin
                    if (len_next[TEXT_ADDR_WIDTH])
                    begin
                        res[n[1:0]] = ctt_pkg::err_res(line_reg, col_reg);
                        n = n + 3'd1;
                        phase_next = ctt_pkg::PH_ERROR;
                    end
                    else
                    begin
                        res[n[1:0]] = ctt_pkg::wr_res(16'(len_next[TEXT_ADDR_WIDTH-1:0]),
                                                      ctt_pkg::CH_NUL);
                        n = n + 3'd1;
                        len_next = len_next + LenW'(1);
                        res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_STRING, 31'(start_reg));
                        n = n + 3'd1;
                        res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_EOF, 31'd0);
                        n = n + 3'd1;
                        phase_next = ctt_pkg::PH_DONE;
                    end
                end
                ctt_pkg::PH_NUMBER:
                begin
                    res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_INT, acc_reg);
                    n = n + 3'd1;
                    res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_EOF, 31'd0);
                    n = n + 3'd1;
                    phase_next = ctt_pkg::PH_DONE;
                end
                ctt_pkg::PH_OPEN:
                begin
                    res[n[1:0]] = ctt_pkg::err_res(bline_reg, bcol_reg);
                    n = n + 3'd1;
                    phase_next = ctt_pkg::PH_ERROR;
                end
                ctt_pkg::PH_BLOCK:
                begin
                    res[n[1:0]] = ctt_pkg::err_res(line_reg, col_reg);
                    n = n + 3'd1;
                    phase_next = ctt_pkg::PH_ERROR;
                end
                default:
                begin
                    res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_EOF, 31'd0);
                    n = n + 3'd1;
                    phase_next = ctt_pkg::PH_DONE;
                end
            endcase
        end
        else if (phase_reg != ctt_pkg::PH_DONE)
        begin
            case (phase_reg)
                ctt_pkg::PH_IDENT:
                begin
                    if (ctt_pkg::is_alpha(char_byte) || ctt_pkg::is_digit(char_byte))
                    begin
                        if (len_next[TEXT_ADDR_WIDTH])
                        begin
                            res[n[1:0]] = ctt_pkg::err_res(line_reg, col_reg);
                            n = n + 3'd1;
                            phase_next = ctt_pkg::PH_ERROR;
                        end
                        else
                        begin
                            res[n[1:0]] = ctt_pkg::wr_res(
                                16'(len_next[TEXT_ADDR_WIDTH-1:0]), char_byte);
                            n = n + 3'd1;
                            len_next = len_next + LenW'(1);
                        end
                    end
                    else if (len_next[TEXT_ADDR_WIDTH])
                    begin
                        res[n[1:0]] = ctt_pkg::err_res(line_reg, col_reg);
                        n = n + 3'd1;
                        phase_next = ctt_pkg::PH_ERROR;
                    end
                    else
                    begin
                        res[n[1:0]] = ctt_pkg::wr_res(16'(len_next[TEXT_ADDR_WIDTH-1:0]),
                                                      ctt_pkg::CH_NUL);
                        n = n + 3'd1;
                        len_next = len_next + LenW'(1);
                        res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_STRING, 31'(start_reg));
                        n = n + 3'd1;
                        phase_next = ctt_pkg::PH_IDLE;
                        disp = 1'b1;
                    end
                end
                ctt_pkg::PH_NUMBER:
                begin
                    if (ctt_pkg::is_digit(char_byte))
                    begin
                        // saturate at the largest 31-bit value
                        acc_next = (acc_sum > 35'(ctt_pkg::INT_MAX)) ? ctt_pkg::INT_MAX
                                                                     : acc_sum[30:0];
                    end
                    else
                    begin
                        res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_INT, acc_reg);
                        n = n + 3'd1;
                        phase_next = ctt_pkg::PH_IDLE;
                        disp = 1'b1;
                    end
                end
                ctt_pkg::PH_OPEN:
                begin
                    if (char_byte == ctt_pkg::CH_LBRACE)
                    begin
                        if (brace_reg == 2'd2)
                        begin
                            brace_next = 2'd0;
                            start_next = len_reg[TEXT_ADDR_WIDTH-1:0];
                            phase_next = ctt_pkg::PH_BLOCK;
                        end
                        else
                        begin
                            brace_next = brace_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        res[n[1:0]] = ctt_pkg::err_res(bline_reg, bcol_reg);
                        n = n + 3'd1;
                        phase_next = ctt_pkg::PH_ERROR;
                    end
                end
                ctt_pkg::PH_BLOCK:
                begin
                    if (char_byte == ctt_pkg::CH_RBRACE)
                    begin
                        if (brace_reg == 2'd2)
                        begin
                            brace_next = 2'd0;
                            if (len_next[TEXT_ADDR_WIDTH])
                            begin
                                res[n[1:0]] = ctt_pkg::err_res(line_reg, col_reg);
                                n = n + 3'd1;
                                phase_next = ctt_pkg::PH_ERROR;
                            end
                            else
                            begin
                                res[n[1:0]] = ctt_pkg::wr_res(
                                    16'(len_next[TEXT_ADDR_WIDTH-1:0]), ctt_pkg::CH_NUL);
                                n = n + 3'd1;
                                len_next = len_next + LenW'(1);
                                res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_OPEN, 31'd0);
                                n = n + 3'd1;
                                res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_STRING,
                                                               31'(start_reg));
                                n = n + 3'd1;
                                res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_CLOSE, 31'd0);
                                n = n + 3'd1;
                                phase_next = ctt_pkg::PH_IDLE;
                            end
                        end
                        else
                        begin
                            brace_next = brace_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        // pending closing braces become body bytes first
                        if (brace_reg != 2'd0)
                        begin
                            if (len_next[TEXT_ADDR_WIDTH])
                            begin
                                res[n[1:0]] = ctt_pkg::err_res(line_reg, col_reg);
                                n = n + 3'd1;
                                phase_next = ctt_pkg::PH_ERROR;
                                ok = 1'b0;
                            end
                            else
                            begin
                                res[n[1:0]] = ctt_pkg::wr_res(
                                    16'(len_next[TEXT_ADDR_WIDTH-1:0]), ctt_pkg::CH_RBRACE);
                                n = n + 3'd1;
                                len_next = len_next + LenW'(1);
                            end
                        end
                        if (ok && brace_reg == 2'd2)
                        begin
                            if (len_next[TEXT_ADDR_WIDTH])
                            begin
                                res[n[1:0]] = ctt_pkg::err_res(line_reg, col_reg);
                                n = n + 3'd1;
                                phase_next = ctt_pkg::PH_ERROR;
                                ok = 1'b0;
                            end
                            else
                            begin
                                res[n[1:0]] = ctt_pkg::wr_res(
                                    16'(len_next[TEXT_ADDR_WIDTH-1:0]), ctt_pkg::CH_RBRACE);
                                n = n + 3'd1;
                                len_next = len_next + LenW'(1);
                            end
                        end
                        if (ok)
                        begin
                            brace_next = 2'd0;
                            if (len_next[TEXT_ADDR_WIDTH])
                            begin
                                res[n[1:0]] = ctt_pkg::err_res(line_reg, col_reg);
                                n = n + 3'd1;
                                phase_next = ctt_pkg::PH_ERROR;
                            end
                            else
                            begin
                                res[n[1:0]] = ctt_pkg::wr_res(
                                    16'(len_next[TEXT_ADDR_WIDTH-1:0]), char_byte);
                                n = n + 3'd1;
                                len_next = len_next + LenW'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    disp = 1'b1;
                end
            endcase

            // start of a new token from the idle phase, also right after an identifier or number ends
            if (disp)
            begin
                if (char_byte == ctt_pkg::CH_NL)
                begin
                    if (!nl_reg)
                    begin
                        res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_END, 31'd0);
                        n = n + 3'd1;
                    end
                    nl_next = 1'b1;
                end
                else
                begin
                    nl_next = 1'b0;
                    if (char_byte inside {ctt_pkg::CH_SPACE, ctt_pkg::CH_TAB})
                    begin
                        nl_next = 1'b0;
                    end
                    else if (char_byte == ctt_pkg::CH_SLASH)
                    begin
                        res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_SLASH, 31'd0);
                        n = n + 3'd1;
                    end
                    else if (char_byte == ctt_pkg::CH_STAR)
                    begin
                        res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_STAR, 31'd0);
                        n = n + 3'd1;
                    end
                    else if (char_byte == ctt_pkg::CH_DOT)
                    begin
                        res[n[1:0]] = ctt_pkg::tok_res(ctt_pkg::TK_DOT, 31'd0);
                        n = n + 3'd1;
                    end
                    else if (ctt_pkg::is_alpha(char_byte))
                    begin
                        start_next = len_next[TEXT_ADDR_WIDTH-1:0];
                        phase_next = ctt_pkg::PH_IDENT;
                        if (len_next[TEXT_ADDR_WIDTH])
                        begin
                            res[n[1:0]] = ctt_pkg::err_res(line_reg, col_reg);
                            n = n + 3'd1;
                            phase_next = ctt_pkg::PH_ERROR;
                        end
                        else
                        begin
                            res[n[1:0]] = ctt_pkg::wr_res(
                                16'(len_next[TEXT_ADDR_WIDTH-1:0]), char_byte);
                            n = n + 3'd1;
                            len_next = len_next + LenW'(1);
                        end
                    end
                    else if (ctt_pkg::is_digit(char_byte))
                    begin
                        acc_next   = 31'(char_byte - ctt_pkg::CH_ZERO);
                        phase_next = ctt_pkg::PH_NUMBER;
                    end
                    else if (char_byte == ctt_pkg::CH_LBRACE)
                    begin
                        brace_next = 2'd1;
                        bline_next = line_reg;
                        bcol_next  = col_reg;
                        phase_next = ctt_pkg::PH_OPEN;
                    end
                    else
                    begin
                        res[n[1:0]] = ctt_pkg::err_res(line_reg, col_reg);
                        n = n + 3'd1;
                        phase_next = ctt_pkg::PH_ERROR;
                    end
                end
            end

            // position of the next byte, saturating
            if (char_byte == ctt_pkg::CH_NL)
            begin
                if (line_reg != ctt_pkg::LINE_MAX)
                begin
                    line_next = line_reg + 20'd1;
                end
                col_next = 16'd1;
            end
            else if (col_reg != ctt_pkg::COL_MAX)
            begin
                col_next = col_reg + 16'd1;
            end
        end

        batch.count = n;
        batch.res   = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ctt_pkg::PH_IDLE;
            brace_reg <= 2'd0;
            acc_reg   <= '0;
            len_reg   <= '0;
            start_reg <= '0;
            line_reg  <= 20'd1;
            col_reg   <= 16'd1;
            nl_reg    <= 1'b0;
            bline_reg <= 20'd1;
            bcol_reg  <= 16'd1;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            brace_reg <= brace_next;
            acc_reg   <= acc_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            nl_reg    <= nl_next;
            bline_reg <= bline_next;
            bcol_reg  <= bcol_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ctt_result_buf.sv
// result register: holds one item's results, hands one out per cycle while ready
// depends on ctt_pkg and ctt_token_if
`default_nettype none

module ctt_result_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire ctt_pkg::batch_t  batch,
    output logic                  free,
    ctt_token_if.source           res_out
);

    ctt_pkg::res_t [ctt_pkg::MAX_RESULTS-1:0] res_reg;
    logic [2:0]     count_reg;
    logic [1:0]     head_reg;
    logic           has;
    logic           last;
    logic           pop;
    ctt_pkg::res_t  cur;

    assign has  = (count_reg != 3'd0);
    assign last = ({1'b0, head_reg} + 3'd1) == count_reg;
    assign pop  = has && res_out.ready;
    // the buffer can take a new batch once its last result leaves
    assign free = !has || (res_out.ready && last);
    assign cur  = res_reg[head_reg];

    assign res_out.valid        = has;
    assign res_out.result_kind  = cur.result_kind;
    assign res_out.token_kind   = cur.token_kind;
    assign res_out.token_value  = cur.token_value;
    assign res_out.text_addr    = cur.text_addr;
    assign res_out.text_byte    = cur.text_byte;
    assign res_out.error_line   = cur.error_line;
    assign res_out.error_column = cur.error_column;
    assign res_out.last_result  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
            head_reg  <= 2'd0;
        end
        else if (load)
        begin
            count_reg <= batch.count;
            head_reg  <= 2'd0;
        end
        else if (pop)
        begin
            if (last)
            begin
                count_reg <= 3'd0;
            end
            head_reg <= head_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= batch.res;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// testbench of config_text_tokenizer: directed and random character items, checked
// result by result against a predictor held in a small scoreboard class
// depends on ctt_pkg, ctt_if and the config_text_tokenizer rtl

module tb;

    import ctt_pkg::*;

    // a small text store makes the full-store error reachable in a short run
    localparam int TEXT_AW     = 8;
    localparam int CYCLE_LIMIT = 1_000_000;

    // one result as it leaves the block, last_result included
    typedef struct packed {
        logic        result_kind;
        logic [3:0]  token_kind;
        logic [30:0] token_value;
        logic [15:0] text_addr;
        logic [7:0]  text_byte;
        logic [19:0] error_line;
        logic [15:0] error_column;
        logic        last_result;
    } tok_result_t;

    // lexer predictor plus the queue of results it still waits for
    class tokenizer_scoreboard;
        tok_result_t  expected_q[$];
        tok_result_t  item_results[$];
        phase_t       phase;
        int unsigned  brace_run;
        logic [30:0]  number_acc;
        int unsigned  text_len;
        int unsigned  string_start;
        int unsigned  line_no;
        int unsigned  col_no;
        bit           nl_seen;
        int unsigned  open_line;
        int unsigned  open_col;
        int unsigned  store_size;
        int unsigned  results_seen;

        function new(int unsigned size);
            store_size   = size;
            phase        = PH_IDLE;
            brace_run    = 0;
            number_acc   = '0;
            text_len     = 0;
            string_start = 0;
            line_no      = 1;
            col_no       = 1;
            nl_seen      = 0;
            open_line    = 1;
            open_col     = 1;
            results_seen = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function bit in_error();
            return phase == PH_ERROR;
        endfunction

        function bit is_letter(logic [7:0] c);
            // a-z, A-Z
            return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
        endfunction

        function bit is_numeral(logic [7:0] c);
            return c >= CH_ZERO && c <= 8'h39;
        endfunction

        // at most four results per item
        function void add_result(tok_result_t r);
            if (item_results.size() < MAX_RESULTS)
                item_results.push_back(r);
        endfunction

        function void emit_token(logic [3:0] kind, logic [30:0] value);
            tok_result_t r;
            r             = '0;
            r.result_kind = RK_TOKEN;
            r.token_kind  = kind;
            r.token_value = value;
            add_result(r);
        endfunction

        function void raise_error(int unsigned l, int unsigned c);
            tok_result_t r;
            r              = '0;
            r.result_kind  = RK_TOKEN;
            r.token_kind   = TK_ERROR;
            r.error_line   = l[19:0];
            r.error_column = c[15:0];
            add_result(r);
            phase = PH_ERROR;
        endfunction

        // a write into a full store turns into an error
        function bit store_byte(logic [7:0] b);
            tok_result_t r;
            if (text_len >= store_size)
            begin
                raise_error(line_no, col_no);
                return 0;
            end
            r             = '0;
            r.result_kind = RK_WRITE;
            r.text_addr   = text_len[15:0];
            r.text_byte   = b;
            add_result(r);
            text_len++;
            return 1;
        endfunction

        // a character seen outside any token
        function void start_token(logic [7:0] c);
            if (c == CH_NL)
            begin
                if (!nl_seen)
                    emit_token(TK_END, '0);
                nl_seen = 1;
                return;
            end
            nl_seen = 0;
            if (c == CH_SPACE || c == CH_TAB)
                return;
            if (c == CH_SLASH)
                emit_token(TK_SLASH, '0);
            else if (c == CH_STAR)
                emit_token(TK_STAR, '0);
            else if (c == CH_DOT)
                emit_token(TK_DOT, '0);
            else if (is_letter(c))
            begin
                string_start = text_len;
                phase        = PH_IDENT;
                void'(store_byte(c));
            end
            else if (is_numeral(c))
            begin
                number_acc = 31'(c - CH_ZERO);
                phase      = PH_NUMBER;
            end
            else if (c == CH_LBRACE)
            begin
                brace_run = 1;
                open_line = line_no;
                open_col  = col_no;
                phase     = PH_OPEN;
            end
            else
                raise_error(line_no, col_no);
        endfunction

        function void take_char(logic [7:0] c);
            longint unsigned grown;
            bit              ok;
            int unsigned     k;
            case (phase)
                PH_IDENT:
                begin
                    if (is_letter(c) || is_numeral(c))
                        void'(store_byte(c));
                    else if (store_byte(CH_NUL))
                    begin
                        emit_token(TK_STRING, 31'(string_start));
                        phase = PH_IDLE;
                        start_token(c);
                    end
                end
                PH_NUMBER:
                begin
                    if (is_numeral(c))
                    begin
                        grown = 64'(number_acc) * 64'd10 + 64'(c) - 64'(CH_ZERO);
                        number_acc = (grown > 64'(INT_MAX)) ? INT_MAX : grown[30:0];
                    end
                    else
                    begin
                        emit_token(TK_INT, number_acc);
                        phase = PH_IDLE;
                        start_token(c);
                    end
                end
                PH_OPEN:
                begin
                    if (c == CH_LBRACE)
                    begin
                        brace_run++;
                        if (brace_run >= 3)
                        begin
                            brace_run    = 0;
                            string_start = text_len;
                            phase        = PH_BLOCK;
                        end
                    end
                    else
                        raise_error(open_line, open_col);
                end
                PH_BLOCK:
                begin
                    if (c == CH_RBRACE)
                    begin
                        if (brace_run >= 2)
                        begin
                            // closing triple: terminator, then open, string, close
                            brace_run = 0;
                            if (store_byte(CH_NUL))
                            begin
                                emit_token(TK_OPEN, '0);
                                emit_token(TK_STRING, 31'(string_start));
                                emit_token(TK_CLOSE, '0);
                                phase = PH_IDLE;
                            end
                        end
                        else
                            brace_run++;
                    end
                    else
                    begin
                        // held-back braces are body bytes, written before this one
                        ok = 1;
                        for (k = 0; k < brace_run && ok; k++)
                            ok = store_byte(CH_RBRACE);
                        if (ok)
                        begin
                            brace_run = 0;
                            void'(store_byte(c));
                        end
                    end
                end
                default:
                    start_token(c);
            endcase
            if (c == CH_NL)
            begin
                if (line_no < LINE_MAX)
                    line_no++;
                col_no = 1;
            end
            else if (col_no < COL_MAX)
                col_no++;
        endfunction

        // called for every accepted input item
        function void note_item(logic [7:0] c, logic eoi);
            tok_result_t r;
            item_results.delete();
            if (phase == PH_ERROR)
                return;
            if (eoi)
            begin
                case (phase)
                    PH_IDENT:
                    begin
                        if (store_byte(CH_NUL))
                        begin
                            emit_token(TK_STRING, 31'(string_start));
                            emit_token(TK_EOF, '0);
                            phase = PH_DONE;
                        end
                    end
                    PH_NUMBER:
                    begin
                        emit_token(TK_INT, number_acc);
                        emit_token(TK_EOF, '0);
                        phase = PH_DONE;
                    end
                    PH_OPEN:
                        raise_error(open_line, open_col);
                    PH_BLOCK:
                        raise_error(line_no, col_no);
                    default:
                    begin
                        emit_token(TK_EOF, '0);
                        phase = PH_DONE;
                    end
                endcase
            end
            else if (phase != PH_DONE)
                take_char(c);
            if (item_results.size() > 0)
            begin
                r = item_results.pop_back();
                r.last_result = 1'b1;
                item_results.push_back(r);
            end
            foreach (item_results[i])
                expected_q.push_back(item_results[i]);
        endfunction

        // compare one accepted result with the oldest expectation
        function bit check_result(tok_result_t got, output string why);
            tok_result_t want;
            why = "";
            results_seen++;
            if (expected_q.size() == 0)
            begin
                why = $sformatf("result %0d: none expected (kind %0d token %0d)",
                                results_seen, got.result_kind, got.token_kind);
                return 0;
            end
            want = expected_q.pop_front();
            if (got.result_kind !== want.result_kind)
                why = {why, $sformatf(" result_kind %0d/%0d", got.result_kind, want.result_kind)};
            if (got.token_kind !== want.token_kind)
                why = {why, $sformatf(" token_kind %0d/%0d", got.token_kind, want.token_kind)};
            if (got.token_value !== want.token_value)
                why = {why, $sformatf(" token_value %0d/%0d", got.token_value, want.token_value)};
            if (got.text_addr !== want.text_addr)
                why = {why, $sformatf(" text_addr %0d/%0d", got.text_addr, want.text_addr)};
            if (got.text_byte !== want.text_byte)
                why = {why, $sformatf(" text_byte %0h/%0h", got.text_byte, want.text_byte)};
            if (got.error_line !== want.error_line)
                why = {why, $sformatf(" error_line %0d/%0d", got.error_line, want.error_line)};
            if (got.error_column !== want.error_column)
                why = {why, $sformatf(" error_column %0d/%0d", got.error_column,
                                      want.error_column)};
            if (got.last_result !== want.last_result)
                why = {why, $sformatf(" last_result %0d/%0d", got.last_result, want.last_result)};
            if (why != "")
                why = {$sformatf("result %0d (got/expected):", results_seen), why};
            return why == "";
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ctt_char_if  char_in ();
    ctt_token_if tok_out ();

    config_text_tokenizer #(
        .TEXT_ADDR_WIDTH (TEXT_AW)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .tok_out (tok_out)
    );

    tokenizer_scoreboard board;
    int unsigned         mismatch_count = 0;
    int unsigned         cycle_count    = 0;
    int unsigned         items_sent     = 0;
    int unsigned         burst_left     = 0;
    tok_result_t         seen_result;
    string               mismatch_note;

    // receiver stall pattern state
    int unsigned rx_mode   = 0;
    int unsigned rx_left   = 0;
    int unsigned rx_stride = 2;
    int unsigned rx_tick   = 0;

    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        char_in.valid         = 1'b0;
        char_in.char_byte     = '0;
        char_in.end_of_input  = 1'b0;
        tok_out.ready         = 1'b0;
        board                 = new(1 << TEXT_AW);
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string note);
        mismatch_count++;
        // keep the log short when the block is badly off
        if (mismatch_count <= 100)
            $display("mismatch: %s", note);
    endtask

    // everything is sampled at the rising edge: inputs first, then results
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("config_text_tokenizer regression: fail");
            $finish;
        end
        if (rst_n)
        begin
            if (char_in.valid && char_in.ready)
                board.note_item(char_in.char_byte, char_in.end_of_input);
            if (tok_out.valid && tok_out.ready)
            begin
                seen_result.result_kind  = tok_out.result_kind;
                seen_result.token_kind   = tok_out.token_kind;
                seen_result.token_value  = tok_out.token_value;
                seen_result.text_addr    = tok_out.text_addr;
                seen_result.text_byte    = tok_out.text_byte;
                seen_result.error_line   = tok_out.error_line;
                seen_result.error_column = tok_out.error_column;
                seen_result.last_result  = tok_out.last_result;
                if (!board.check_result(seen_result, mismatch_note))
                    report_mismatch(mismatch_note);
            end
        end
    end

    // receiver: stretches of full rate, random stalls and a fixed stride,
    // so the result buffer is caught both draining and backed up
    always @(negedge clk)
    begin
        if (!rst_n)
            tok_out.ready <= 1'b0;
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode   = $urandom_range(0, 2);
                rx_left   = $urandom_range(20, 80);
                rx_stride = $urandom_range(2, 5);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0:       tok_out.ready <= 1'b1;
                1:       tok_out.ready <= ($urandom_range(0, 2) != 0);
                default: tok_out.ready <= (rx_tick % rx_stride == 0);
            endcase
        end
    end

    // one item, in bursts with random gaps; returns at the falling edge after
    // acceptance with valid still high so the next item can follow at once
    task automatic send_item(input logic [7:0] c, input logic eoi);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                char_in.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        char_in.valid        <= 1'b1;
        char_in.char_byte    <= c;
        char_in.end_of_input <= eoi;
        @(posedge clk);
        while (!char_in.ready)
            @(posedge clk);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // stop sending until every predicted result has come out
    task automatic drain_results();
        char_in.valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_letter();
        int unsigned n;
        n = $urandom_range(0, 25);
        return ($urandom_range(0, 1) != 0) ? 8'(8'h41 + n) : 8'(8'h61 + n);
    endfunction

    // any byte but a closing brace, so a body never closes by accident
    function automatic logic [7:0] pick_body_byte();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == CH_RBRACE);
        return c;
    endfunction

    // a byte the lexer does not know outside a block body
    function automatic logic [7:0] pick_bad_byte();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
            return 8'hff;
        do
            c = 8'($urandom);
        while (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_SLASH ||
               c == CH_STAR || c == CH_DOT || c == CH_LBRACE || board.is_letter(c) ||
               board.is_numeral(c));
        return c;
    endfunction

    task automatic send_word();
        repeat ($urandom_range(1, 7))
        begin
            if ($urandom_range(0, 2) == 0)
                send_item(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
            else
                send_item(pick_letter(), 1'b0);
        end
    endtask

    // mostly short numbers, now and then long enough to saturate
    task automatic send_number();
        int unsigned n;
        bit          nines;
        n     = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
        nines = $urandom_range(0, 1);
        repeat (n)
            send_item(nines ? 8'h39 : 8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
    endtask

    // well-formed block; single and double closing braces inside the body
    // are always followed by an ordinary body byte
    task automatic send_block(input int unsigned body_len);
        repeat (3) send_item(CH_LBRACE, 1'b0);
        repeat (body_len)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 2)) send_item(CH_RBRACE, 1'b0);
            send_item(pick_body_byte(), 1'b0);
        end
        repeat (3) send_item(CH_RBRACE, 1'b0);
    endtask

    initial
    begin
        string       lead;
        logic [7:0]  c;
        int unsigned target;
        int unsigned ending;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: identifier, every punctuation, newline run, zero,
        // a body holding the byte extremes and single and double braces
        lead = "Ab9 /*.\n\n\t0.";
        for (int i = 0; i < lead.len(); i++)
            send_item(lead[i], 1'b0);
        repeat (3) send_item(CH_LBRACE, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(CH_RBRACE, 1'b0);
        send_item(CH_RBRACE, 1'b0);
        send_item(8'h71, 1'b0);
        send_item(CH_RBRACE, 1'b0);
        send_item(8'h77, 1'b0);
        repeat (3) send_item(CH_RBRACE, 1'b0);

        // random well-formed text; errors and end of input are final, so
        // they only come at the very end
        target = items_sent + 110;
        while (items_sent < target)
        begin
            case ($urandom_range(0, 9))
                0, 1: send_word();
                2, 3: send_number();
                4:
                begin
                    case ($urandom_range(0, 2))
                        0:       send_item(CH_SLASH, 1'b0);
                        1:       send_item(CH_STAR, 1'b0);
                        default: send_item(CH_DOT, 1'b0);
                    endcase
                end
                5: repeat ($urandom_range(1, 3))
                       send_item(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB, 1'b0);
                6: repeat ($urandom_range(1, 3)) send_item(CH_NL, 1'b0);
                default: send_block($urandom_range(0, 8));
            endcase
            // hold-off: let the block run empty mid-stream while the item count is in a set window
            if (items_sent >= target - 55 && items_sent < target - 45)
                drain_results();
            else if ($urandom_range(0, 40) == 0)
                drain_results();
        end

        ending = $urandom_range(0, 4);
        case (ending)
            0:
            begin
                // clean end of input, sometimes right after an open word or number
                case ($urandom_range(0, 2))
                    0:       send_word();
                    1:       send_number();
                    default: ;
                endcase
                send_item(8'($urandom), 1'b1);
            end
            1:
            begin
                // broken brace triple, ended by a stray byte or end of input
                send_item(CH_LBRACE, 1'b0);
                if ($urandom_range(0, 1) != 0)
                    send_item(CH_LBRACE, 1'b0);
                if ($urandom_range(0, 2) == 0)
                    send_item(8'($urandom), 1'b1);
                else
                begin
                    do
                        c = 8'($urandom);
                    while (c == CH_LBRACE);
                    send_item(c, 1'b0);
                end
            end
            2:
            begin
                // block left open at end of input
                repeat (3) send_item(CH_LBRACE, 1'b0);
                repeat ($urandom_range(0, 5)) send_item(pick_body_byte(), 1'b0);
                if ($urandom_range(0, 1) != 0)
                    send_item(CH_RBRACE, 1'b0);
                send_item(8'($urandom), 1'b1);
            end
            3:
                send_item(pick_bad_byte(), 1'b0);
            default:
            begin
                // fill the text store through one long block body
                repeat (3) send_item(CH_LBRACE, 1'b0);
                while (!board.in_error())
                    send_item(pick_body_byte(), 1'b0);
            end
        endcase

        // after an error nothing comes out; after end of input only more eof tokens
        repeat ($urandom_range(3, 8))
            send_item(8'($urandom), ($urandom_range(0, 2) == 0));

        drain_results();
        repeat (20) @(negedge clk);
        if (board.pending() != 0)
            report_mismatch($sformatf("%0d expected results never came", board.pending()));
        if (mismatch_count == 0)
            $display("config_text_tokenizer regression: pass");
        else
            $display("config_text_tokenizer regression: fail");
        $finish;
    end

endmodule

>>> config_text_tokenizer.f
rtl/ctt_pkg.sv
rtl/ctt_if.sv
rtl/ctt_lexer.sv
rtl/ctt_result_buf.sv
rtl/config_text_tokenizer.sv
tb/sv/tb.sv
